FILE: hdl/life_grid_generation_step_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the life grid generation step block
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_STEP_MACROS_SVH
`define LIFE_GRID_GENERATION_STEP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define LGS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lgs assertion failed");

// Property holds at every clock edge out of reset.
`define LGS_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("lgs assertion failed");

`endif

FILE: hdl/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Grid size, action codes and the command struct shared by the row cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

	localparam int GRID_WIDTH  = 64;
	localparam int GRID_HEIGHT = 64;
	localparam int COL_W       = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;

	typedef enum logic [1:0] {
		ACT_WRITE   = 2'd0,
		ACT_READ    = 2'd1,
		ACT_ADVANCE = 2'd2
	} action_t;

	// command broadcast to every row cell for one accepted beat
	typedef struct packed {
		logic             load;
		logic             wr;
		logic             rd;
		logic             adv;
		logic [COL_W-1:0] col;
		logic             val;
	} lgs_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/lgs_cell.sv
// ----------------------------------------------------------------------------
// lgs_cell
// One grid row: holds its cells, applies B3/S23 from the rows above and below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgs_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lgs_pkg::lgs_cmd_t             cmd,
	input  logic                          sel,
	input  logic [lgs_pkg::GRID_WIDTH-1:0] above,
	input  logic [lgs_pkg::GRID_WIDTH-1:0] below,
	output logic [lgs_pkg::GRID_WIDTH-1:0] cells,
	output logic                          hit
);
	import lgs_pkg::*;

	logic [GRID_WIDTH-1:0] row_q;
	logic [GRID_WIDTH-1:0] next_row;
	logic                  hit_s1;
	logic [GRID_WIDTH+1:0] a_p;
	logic [GRID_WIDTH+1:0] b_p;
	logic [GRID_WIDTH+1:0] m_p;

	// pad with dead cells so the edges do not wrap
	assign a_p = {1'b0, above, 1'b0};
	assign b_p = {1'b0, below, 1'b0};
	assign m_p = {1'b0, row_q, 1'b0};

	always_comb begin
		logic [3:0] n;
		n = 4'd0;
		for (int c = 0; c < GRID_WIDTH; c++) begin
			n = 4'(a_p[c]) + 4'(a_p[c+1]) + 4'(a_p[c+2])
				+ 4'(m_p[c]) + 4'(m_p[c+2])
				+ 4'(b_p[c]) + 4'(b_p[c+1]) + 4'(b_p[c+2]);
			next_row[c] = (n == 4'd3) | (row_q[c] & (n == 4'd2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			hit_s1 <= 1'b0;
		end else if (cmd.load) begin
			if (cmd.adv) begin
				row_q <= next_row;
			end else if (cmd.wr && sel) begin
				row_q[cmd.col] <= cmd.val;
			end
			hit_s1 <= cmd.rd & sel & row_q[cmd.col];
		end
	end

	assign cells = row_q;
	assign hit   = hit_s1;

endmodule

`default_nettype wire

FILE: hdl/life_grid_generation_step.sv
// ----------------------------------------------------------------------------
// life_grid_generation_step: bounded B3/S23 grid, write / read / advance beats
// Pipeline: input beat -> stage 1 -> output register; an advance updates the rows when accepted.
// Throughput: one beat per cycle unless the sink stalls; row cells update in parallel.
// Reset: arst_n clears every cell to dead and empties the result pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "life_grid_generation_step_macros.svh"

module life_grid_generation_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // action[1:0], row[7:2], col[13:8], cell_in[14], zero[15]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // cell_out[0], zero[7:1]
);
	import lgs_pkg::*;

	logic [1:0] action;
	logic [5:0] row;
	logic [5:0] col;
	logic       cell_in;
	logic       in_grid;
	logic       accept;

	lgs_cmd_t   cmd;

	// one row of cells per grid row, each seeing its vertical neighbors
	logic [GRID_WIDTH-1:0]  rows [GRID_HEIGHT];
	logic [GRID_HEIGHT-1:0] sel;
	logic [GRID_HEIGHT-1:0] hit_vec;

	// stage 1 holds the beat while cells hold their read hit
	logic s1_valid_q;
	logic s1_rd_q;
	logic s1_move;

	// output register parts the two sides
	logic out_valid_q;
	logic out_cell_q;

	// unpack the input beat
	assign action  = s_tdata[1:0];
	assign row     = s_tdata[7:2];
	assign col     = s_tdata[13:8];
	assign cell_in = s_tdata[14];

	// drop writes and reads outside the grid
	assign in_grid = (32'(row) < GRID_HEIGHT) && (32'(col) < GRID_WIDTH);

	// advance stage 1 whenever the output register is free or being taken
	assign s1_move  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_move;
	assign accept   = s_tvalid && s_tready;

	// decode the action into the broadcast command
	always_comb begin
		cmd      = '0;
		cmd.load = accept;
		cmd.col  = COL_W'(col);
		cmd.val  = cell_in;
		case (action)
			ACT_WRITE:   cmd.wr  = in_grid;
			ACT_READ:    cmd.rd  = in_grid;
			ACT_ADVANCE: cmd.adv = 1'b1;
			default:     cmd.load = accept; // unused code: no change, result zero
		endcase
	end

	// row select, one row at most
	for (genvar r = 0; r < GRID_HEIGHT; r++) begin : g_sel
		assign sel[r] = (32'(row) == r);
	end

	for (genvar r = 0; r < GRID_HEIGHT; r++) begin : g_row
		logic [GRID_WIDTH-1:0] above;
		logic [GRID_WIDTH-1:0] below;

		// rows past the top and bottom edge count as dead
		if (r == 0) begin : g_top
			assign above = '0;
		end else begin : g_mid_a
			assign above = rows[r-1];
		end
		if (r == GRID_HEIGHT-1) begin : g_bot
			assign below = '0;
		end else begin : g_mid_b
			assign below = rows[r+1];
		end

		lgs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.sel    (sel[r]),
			.above  (above),
			.below  (below),
			.cells  (rows[r]),
			.hit    (hit_vec[r])
		);
	end

	// stage 1 control: hold while the output register stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_rd_q <= cmd.rd;
		end
	end

	// output beat: collect the read hit from the row cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_cell_q <= s1_rd_q & (|hit_vec);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_cell_q};

	// backpressure only when both stages are full and the sink stalls
	`LGS_ASSERT_IMP(a_ready_low, !s_tready, s1_valid_q && out_valid_q && !m_tready)
	// a non-read beat leaves no hit in any row
	`LGS_ASSERT_IMP(a_no_hit, s1_valid_q && !s1_rd_q, hit_vec == '0)
	// at most one row answers a read
	`LGS_ASSERT_ALWAYS(a_hit_onehot, $onehot0(hit_vec))

endmodule

`default_nettype wire

FILE: sim/tb_life_grid_generation_step.sv
// ----------------------------------------------------------------------------
// tb_life_grid_generation_step
// Self-checking bench for the bounded B3/S23 life grid. A grid model in the
// bench tracks every write and every generation step and predicts each result
// beat. Random patterns, biased toward the grid edges, are stepped and read
// back, while both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_life_grid_generation_step;

	import lgs_pkg::*;

	localparam logic [1:0] ACT_UNUSED  = 2'd3;   // no-op code, grid untouched
	localparam int         ROW_W       = 6;
	localparam int         SURVIVE_LO  = 2;
	localparam int         LIFE_COUNT  = 3;      // birth, and top of survival
	localparam int         RANDOM_BEATS = 600;
	localparam int         WINDOW      = 6;      // side of a random pattern
	localparam int         STALL_LIMIT = 2000;   // cycles with no beat moving
	localparam int         DRAIN_CYCLES = 8;

	logic              clk;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;

	// grid model and the cell_out values still owed by the block
	logic [GRID_WIDTH-1:0] life_cells [GRID_HEIGHT];
	logic                  pending_cell_out [$];

	int  mismatch_count = 0;
	int  beats_sent     = 0;
	int  idle_cycles    = 0;
	bit  steady_flow    = 1'b0;   // both sides skip idling while set

	life_grid_generation_step dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int draw_wait();
		return steady_flow ? 0 : int'($urandom_range(0, 15));
	endfunction

	// one generation, all cells from the old grid; outside cells count as dead
	function automatic void advance_life_cells();
		logic [GRID_WIDTH-1:0] next_rows [GRID_HEIGHT];
		int live;
		int nr;
		int nc;
		for (int r = 0; r < GRID_HEIGHT; r++) begin
			for (int c = 0; c < GRID_WIDTH; c++) begin
				live = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						nr = r + dr;
						nc = c + dc;
						if ((dr != 0 || dc != 0) && nr >= 0 && nr < GRID_HEIGHT &&
						    nc >= 0 && nc < GRID_WIDTH && life_cells[nr][nc])
							live++;
					end
				end
				if (life_cells[r][c])
					next_rows[r][c] = (live == SURVIVE_LO || live == LIFE_COUNT);
				else
					next_rows[r][c] = (live == LIFE_COUNT);
			end
		end
		life_cells = next_rows;
	endfunction

	// update the grid model for one beat and return the cell_out it yields
	function automatic logic predict_cell_out(logic [1:0] action, logic [ROW_W-1:0] row,
	                                          logic [COL_W-1:0] col, logic cell_in);
		logic result;
		logic on_grid;
		result  = 1'b0;
		on_grid = (row < GRID_HEIGHT) && (col < GRID_WIDTH);
		case (action)
			ACT_WRITE: begin
				if (on_grid)
					life_cells[row][col] = cell_in;
			end
			ACT_READ: begin
				if (on_grid)
					result = life_cells[row][col];
			end
			ACT_ADVANCE: begin
				advance_life_cells();
			end
			default: begin
			end
		endcase
		return result;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] MISMATCH %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Enter and leave at a rising edge. Keep tvalid high across back-to-back beats.
	task automatic send_grid_beat(logic [1:0] action, logic [ROW_W-1:0] row,
	                              logic [COL_W-1:0] col, logic cell_in);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, cell_in, col, row, action};
		do @(posedge clk); while (!s_tready);
		pending_cell_out.push_back(predict_cell_out(action, row, col, cell_in));
		beats_sent++;
	endtask

	task automatic send_advance();
		send_grid_beat(ACT_ADVANCE, ROW_W'($urandom), COL_W'($urandom), 1'($urandom));
	endtask

	// extremes of row and col, both cell values
	task automatic test_corner_cells();
		send_grid_beat(ACT_WRITE, '0, '0, 1'b1);
		send_grid_beat(ACT_WRITE, '0, '1, 1'b1);
		send_grid_beat(ACT_WRITE, '1, '0, 1'b1);
		send_grid_beat(ACT_WRITE, '1, '1, 1'b0);
		send_grid_beat(ACT_READ,  '0, '0, 1'b0);
		send_grid_beat(ACT_READ,  '0, '1, 1'b1);
		send_grid_beat(ACT_READ,  '1, '0, 1'b0);
		send_grid_beat(ACT_READ,  '1, '1, 1'b1);
	endtask

	// the spare action code must leave the addressed cell alone
	task automatic test_unused_action();
		send_grid_beat(ACT_WRITE,  6'd10, 6'd10, 1'b1);
		send_grid_beat(ACT_UNUSED, 6'd10, 6'd10, 1'b0);
		send_grid_beat(ACT_READ,   6'd10, 6'd10, 1'b0);
	endtask

	// Vertical blinker on the right edge, top corner. It turns horizontal with
	// its right end clipped; a wrapping grid would light column 0 instead.
	task automatic test_edge_blinker();
		send_grid_beat(ACT_WRITE, 6'd0, 6'd63, 1'b1);
		send_grid_beat(ACT_WRITE, 6'd1, 6'd63, 1'b1);
		send_grid_beat(ACT_WRITE, 6'd2, 6'd63, 1'b1);
		send_grid_beat(ACT_ADVANCE, '1, '1, 1'b1);
		send_grid_beat(ACT_READ, 6'd1, 6'd62, 1'b1);
		send_grid_beat(ACT_READ, 6'd1, 6'd63, 1'b0);
		send_grid_beat(ACT_READ, 6'd0, 6'd63, 1'b1);
		send_grid_beat(ACT_READ, 6'd2, 6'd63, 1'b0);
		send_grid_beat(ACT_READ, 6'd1, 6'd0,  1'b1);
		send_grid_beat(ACT_READ, 6'd0, 6'd0,  1'b0);
		send_advance();
		send_grid_beat(ACT_READ, 6'd0, 6'd63, 1'b0);
	endtask

	// window origin, biased toward the edges of the grid
	function automatic int pick_origin(int extent);
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return extent - WINDOW;
			default: return $urandom_range(0, extent - WINDOW);
		endcase
	endfunction

	// Seed a small window, step it a few generations, read it back with a margin.
	task automatic test_random_patterns();
		int top;
		int left;
		int r;
		int c;
		int target;
		target = beats_sent + RANDOM_BEATS;
		while (beats_sent < target) begin
			steady_flow = ($urandom_range(0, 3) == 0);
			top  = pick_origin(GRID_HEIGHT);
			left = pick_origin(GRID_WIDTH);
			repeat ($urandom_range(8, 16))
				send_grid_beat(ACT_WRITE, ROW_W'(top + $urandom_range(0, WINDOW - 1)),
				               COL_W'(left + $urandom_range(0, WINDOW - 1)),
				               1'($urandom_range(0, 2) != 0));
			repeat ($urandom_range(1, 3))
				send_advance();
			repeat ($urandom_range(6, 12)) begin
				r = top  + $urandom_range(0, WINDOW + 1) - 1;
				c = left + $urandom_range(0, WINDOW + 1) - 1;
				r = (r < 0) ? 0 : (r >= GRID_HEIGHT) ? GRID_HEIGHT - 1 : r;
				c = (c < 0) ? 0 : (c >= GRID_WIDTH)  ? GRID_WIDTH - 1  : c;
				send_grid_beat(ACT_READ, ROW_W'(r), COL_W'(c), 1'($urandom));
			end
			// noise: any action at any address
			repeat ($urandom_range(0, 3))
				send_grid_beat(2'($urandom), ROW_W'($urandom), COL_W'($urandom), 1'($urandom));
		end
		steady_flow = 1'b0;
	endtask

	// result side: draw a stall, then take one beat
	initial begin
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			int stall;
			stall = draw_wait();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// compare every result beat with the oldest prediction
	always @(posedge clk) begin
		logic expected;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_cell_out.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing expected, tdata %h",
				                          m_tdata));
			end else begin
				expected = pending_cell_out.pop_front();
				if (m_tdata[0] !== expected)
					report_mismatch($sformatf("cell_out %b, expected %b", m_tdata[0],
					                          expected));
				if (m_tdata[7:1] !== '0)
					report_mismatch($sformatf("tdata padding %b, expected zero",
					                          m_tdata[7:1]));
			end
		end
	end

	// end the run when no beat moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		for (int r = 0; r < GRID_HEIGHT; r++)
			life_cells[r] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cells();
		test_unused_action();
		test_edge_blinker();
		test_random_patterns();
		s_tvalid <= 1'b0;

		while (pending_cell_out.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_cell_out.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_cell_out.size()));

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/lgs_pkg.sv
hdl/lgs_cell.sv
hdl/life_grid_generation_step.sv
sim/tb_life_grid_generation_step.sv
